@@ design/arpg_pkg.sv @@
`timescale 1ns / 1ps

package arpg_pkg;

    localparam int DEF_DATA_WIDTH = 16;
    localparam int DEF_FRAC_BITS  = 12;

    // Port and register widths
    localparam int IO_W        = 16;
    localparam int RATE_CFG_W  = 15;
    localparam int PERIOD_W    = 16;
    localparam int PERIOD_FRAC = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Squared current rate is capped at 2**T_CAP_LOG before the deceleration distance product
    localparam int T_CAP_LOG = 40;

    localparam logic [RATE_CFG_W-1:0] MAX_RATE_RST   = 15'd4096;
    localparam logic [RATE_CFG_W-1:0] ACCEL_STEP_RST = 15'd410;
    localparam logic [RATE_CFG_W-1:0] HALF_INV_RST   = 15'd2048;
    localparam logic [PERIOD_W-1:0]   PERIOD_RST     = 16'd6554;
    localparam logic [RATE_CFG_W-1:0] DONE_THR_RST   = 15'd41;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_RATE       = 3'd0,
        CFG_ACCEL_STEP     = 3'd1,
        CFG_HALF_INV_ACCEL = 3'd2,
        CFG_TICK_PERIOD    = 3'd3,
        CFG_DONE_THRESHOLD = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_START = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAUNCH,
        S_WAIT,
        S_DECIDE,
        S_FINISH
    } t_state;

    typedef enum logic [2:0] {
        OP_SQ_ACC,
        OP_DIST_ACC,
        OP_SQ_DEC,
        OP_DIST_DEC,
        OP_TRAVEL,
        OP_STEP
    } t_op;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

@@ design/arpg_serial_mult.sv @@
`timescale 1ns / 1ps

// Unsigned shift-add multiplier, one bit of the B operand per cycle.
module arpg_serial_mult #(
    parameter int A_W = 41,
    parameter int B_W = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [A_W-1:0]         i_a,
    input  logic [B_W-1:0]         i_b,
    output logic [A_W+B_W-1:0]     o_product,
    output arpg_pkg::t_mul_stat    o_stat
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [A_W-1:0]   r_a;
    logic [A_W-1:0]   r_hi;
    logic [B_W-1:0]   r_lo;

    logic [A_W:0]     n_sum;
    logic [A_W-1:0]   n_hi;
    logic [B_W-1:0]   n_lo;

    // Add A when the low multiplier bit is set, then shift the pair right
    always_comb begin
        n_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);
        n_hi  = n_sum[A_W:1];
        n_lo  = {n_sum[0], r_lo[B_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_product   = {r_hi, r_lo};
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("multiplier done while still busy");

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("multiplier busy with no bits left");

    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (!r_busy && !r_done))
        else $error("multiplier started while in use");

endmodule

@@ design/angular_rate_profile_generator.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake               Payload
// in       input      i_in_valid/o_in_stall   i_cmd, i_target_angle
// out      output     o_out_valid/i_out_stall o_rate_out, o_remaining_out, o_done_res
// cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A start item goes from acceptance straight to the finish step and the output register.
// A tick item runs six products one after another through the bit-serial multiplier,
// one bit a cycle.
// One item is in work at a time; the next is taken while the last result waits in
// the output register. Reset is synchronous: rate and remaining angle clear to zero
// and the registers take their reset values. A stalled output holds its result.
module angular_rate_profile_generator #(
    parameter int DATA_WIDTH = arpg_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = arpg_pkg::DEF_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_cmd,
    input  logic signed [arpg_pkg::IO_W-1:0] i_target_angle,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [arpg_pkg::IO_W-1:0] o_rate_out,
    output logic signed [arpg_pkg::IO_W-1:0] o_remaining_out,
    output logic                             o_done_res,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [arpg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [arpg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int DW   = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int RCW  = arpg_pkg::RATE_CFG_W;
    localparam int PDW  = arpg_pkg::PERIOD_W;
    localparam int PFR  = arpg_pkg::PERIOD_FRAC;
    localparam int IOW  = arpg_pkg::IO_W;
    localparam int TCL  = arpg_pkg::T_CAP_LOG;
    localparam int MA   = (TCL + 1 > DW) ? TCL + 1 : DW;
    localparam int MB   = (DW > PDW) ? DW : PDW;
    localparam int MB1  = MB + 1;
    localparam int PW   = MA + MB;
    localparam int TW   = PW - F;
    localparam int VW   = PW - PFR;
    localparam int CPW  = (TW > TCL + 1) ? TW : TCL + 1;
    localparam int EW   = MB + 2;
    localparam int SW   = MB + 1;
    localparam int RW   = DW + 2;
    localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

    arpg_pkg::t_state r_state, n_state;
    arpg_pkg::t_op    r_op, n_op;

    logic [RCW-1:0]       r_max_rate;
    logic [RCW-1:0]       r_accel_step;
    logic [RCW-1:0]       r_half_inv;
    logic [PDW-1:0]       r_period;
    logic [RCW-1:0]       r_done_thr;

    logic signed [DW-1:0] r_rate;
    logic signed [DW-1:0] r_rem;
    logic [MA-1:0]        r_t;
    logic [DW-1:0]        r_d_acc;
    logic [DW-1:0]        r_d_dec;
    logic [DW-1:0]        r_travel;
    logic signed [DW-1:0] r_new_rate;

    logic                 r_out_valid;
    logic [IOW-1:0]       r_o_rate;
    logic [IOW-1:0]       r_o_rem;
    logic                 r_o_done;

    logic                 in_take;
    logic                 out_load;
    logic                 mul_start;
    logic                 step_end;
    logic [MA-1:0]        mul_a;
    logic [MB-1:0]        mul_b;
    logic [PW-1:0]        mul_p;
    arpg_pkg::t_mul_stat  mul_stat;

    logic [DW-1:0]        acur;
    logic [DW-1:0]        arem;
    logic [DW-1:0]        anew;
    logic [MB:0]          ra_sum;
    logic [RCW-1:0]       ra;

    logic [TW-1:0]        t_full;
    logic [CPW-1:0]       t_wide;
    logic [MA-1:0]        n_t_cap;
    logic [DW-1:0]        n_dist;
    logic [VW-1:0]        v_full;
    logic [DW-1:0]        n_travel;

    logic [DW-1:0]        step_q;
    logic [DW:0]          step_mag;
    logic signed [RW-1:0] rem_e;
    logic signed [RW-1:0] rem_diff;
    logic signed [DW-1:0] n_rem;

    logic signed [SW-1:0] start_e;
    logic signed [DW-1:0] n_start_rem;

    logic                 rem_pos;
    logic                 acc_go;
    logic                 dec_go;
    logic signed [EW-1:0] cur_e, st_e, mr_e, neg_mr, up_e, dn_e, nr_e;
    logic signed [DW-1:0] n_new_rate;
    logic                 n_done;

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        mul_start = 1'b0;
        in_take   = 1'b0;
        out_load  = 1'b0;
        step_end  = 1'b0;
        case (r_state)
            arpg_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    in_take = 1'b1;
                    n_op    = arpg_pkg::OP_SQ_ACC;
                    if (i_cmd == arpg_pkg::CMD_START) begin
                        n_state = arpg_pkg::S_FINISH;
                    end else begin
                        n_state = arpg_pkg::S_LAUNCH;
                    end
                end
            end
            arpg_pkg::S_LAUNCH: begin
                mul_start = 1'b1;
                n_state   = arpg_pkg::S_WAIT;
            end
            arpg_pkg::S_WAIT: begin
                if (mul_stat.done) begin
                    n_state = arpg_pkg::S_LAUNCH;
                    case (r_op)
                        arpg_pkg::OP_SQ_ACC:   n_op = arpg_pkg::OP_DIST_ACC;
                        arpg_pkg::OP_DIST_ACC: n_op = arpg_pkg::OP_SQ_DEC;
                        arpg_pkg::OP_SQ_DEC:   n_op = arpg_pkg::OP_DIST_DEC;
                        arpg_pkg::OP_DIST_DEC: n_op = arpg_pkg::OP_TRAVEL;
                        arpg_pkg::OP_TRAVEL: begin
                            n_op    = arpg_pkg::OP_STEP;
                            n_state = arpg_pkg::S_DECIDE;
                        end
                        arpg_pkg::OP_STEP: begin
                            step_end = 1'b1;
                            n_state  = arpg_pkg::S_FINISH;
                        end
                        default: n_state = arpg_pkg::S_IDLE;
                    endcase
                end
            end
            arpg_pkg::S_DECIDE: begin
                n_state = arpg_pkg::S_LAUNCH;
            end
            arpg_pkg::S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = arpg_pkg::S_IDLE;
                end
            end
            default: n_state = arpg_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- operands
    always_comb begin
        acur   = r_rate[DW-1] ? DW'(~r_rate + 1'b1) : DW'(r_rate);
        arem   = r_rem[DW-1] ? DW'(~r_rem + 1'b1) : DW'(r_rem);
        anew   = r_new_rate[DW-1] ? DW'(~r_new_rate + 1'b1) : DW'(r_new_rate);
        ra_sum = MB1'(acur) + MB1'(r_accel_step);
        ra     = (ra_sum > MB1'(r_max_rate)) ? r_max_rate : ra_sum[RCW-1:0];
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_op)
            arpg_pkg::OP_SQ_ACC: begin
                mul_a = MA'(ra);
                mul_b = MB'(ra);
            end
            arpg_pkg::OP_DIST_ACC, arpg_pkg::OP_DIST_DEC: begin
                mul_a = r_t;
                mul_b = MB'(r_half_inv);
            end
            arpg_pkg::OP_SQ_DEC: begin
                mul_a = MA'(acur);
                mul_b = MB'(acur);
            end
            arpg_pkg::OP_TRAVEL: begin
                mul_a = MA'(acur);
                mul_b = MB'(r_period);
            end
            arpg_pkg::OP_STEP: begin
                mul_a = MA'(anew);
                mul_b = MB'(r_period);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    arpg_serial_mult #(
        .A_W (MA),
        .B_W (MB)
    ) u_mult (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_product (mul_p),
        .o_stat    (mul_stat)
    );

    // ---------------------------------------------------------------- product handling
    always_comb begin
        t_full   = mul_p[PW-1:F];
        t_wide   = CPW'(t_full);
        // cap the squared rate before the distance product
        if (t_wide > (CPW'(1) << TCL)) begin
            n_t_cap = MA'(CPW'(1) << TCL);
        end else begin
            n_t_cap = MA'(t_wide);
        end
        n_dist   = (|t_full[TW-1:DW]) ? '1 : t_full[DW-1:0];
        v_full   = mul_p[PW-1:PFR];
        n_travel = (|v_full[VW-1:DW]) ? '1 : v_full[DW-1:0];

        // floor of a negative step rounds the magnitude up
        step_q   = mul_p[PFR +: DW];
        step_mag = {1'b0, step_q} + (DW+1)'(r_new_rate[DW-1] && (|mul_p[PFR-1:0]));
        rem_e    = {{2{r_rem[DW-1]}}, r_rem};
        if (r_new_rate[DW-1]) begin
            rem_diff = rem_e + $signed({1'b0, step_mag});
        end else begin
            rem_diff = rem_e - $signed({1'b0, step_mag});
        end
        if (!rem_diff[RW-1] && (|rem_diff[RW-2:DW-1])) begin
            n_rem = SMAX;
        end else if (rem_diff[RW-1] && !(&rem_diff[RW-2:DW-1])) begin
            n_rem = SMIN;
        end else begin
            n_rem = rem_diff[DW-1:0];
        end
    end

    // Start angle saturates into the state width
    always_comb begin
        start_e = {{(SW-IOW){i_target_angle[IOW-1]}}, i_target_angle};
        if (!start_e[SW-1] && (|start_e[SW-2:DW-1])) begin
            n_start_rem = SMAX;
        end else if (start_e[SW-1] && !(&start_e[SW-2:DW-1])) begin
            n_start_rem = SMIN;
        end else begin
            n_start_rem = start_e[DW-1:0];
        end
    end

    // ---------------------------------------------------------------- rate decision
    always_comb begin
        rem_pos = !r_rem[DW-1] && (r_rem != '0);
        acc_go  = r_d_acc < arem;
        dec_go  = ({1'b0, r_d_dec} + {1'b0, r_travel}) > {1'b0, arem};
        cur_e   = {{(EW-DW){r_rate[DW-1]}}, r_rate};
        st_e    = $signed({{(EW-RCW){1'b0}}, r_accel_step});
        mr_e    = $signed({{(EW-RCW){1'b0}}, r_max_rate});
        neg_mr  = -mr_e;
        up_e    = cur_e + st_e;
        dn_e    = cur_e - st_e;
        if (acc_go) begin
            if (rem_pos) begin
                nr_e = (up_e > mr_e) ? mr_e : up_e;
            end else begin
                nr_e = (dn_e < neg_mr) ? neg_mr : dn_e;
            end
        end else if (dec_go) begin
            // approach zero without crossing it
            if (rem_pos) begin
                nr_e = (dn_e < 0) ? '0 : dn_e;
            end else begin
                nr_e = (up_e > 0) ? '0 : up_e;
            end
        end else begin
            nr_e = cur_e;
        end
        if (!nr_e[EW-1] && (|nr_e[EW-2:DW-1])) begin
            n_new_rate = SMAX;
        end else if (nr_e[EW-1] && !(&nr_e[EW-2:DW-1])) begin
            n_new_rate = SMIN;
        end else begin
            n_new_rate = nr_e[DW-1:0];
        end
        n_done = MB'(arem) <= MB'(r_done_thr);
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= arpg_pkg::S_IDLE;
            r_op         <= arpg_pkg::OP_SQ_ACC;
            r_out_valid  <= 1'b0;
            r_rate       <= '0;
            r_rem        <= '0;
            r_max_rate   <= arpg_pkg::MAX_RATE_RST;
            r_accel_step <= arpg_pkg::ACCEL_STEP_RST;
            r_half_inv   <= arpg_pkg::HALF_INV_RST;
            r_period     <= arpg_pkg::PERIOD_RST;
            r_done_thr   <= arpg_pkg::DONE_THR_RST;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_take && (i_cmd == arpg_pkg::CMD_START)) begin
                r_rate <= '0;
                r_rem  <= n_start_rem;
            end else if (step_end) begin
                r_rate <= r_new_rate;
                r_rem  <= n_rem;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    arpg_pkg::CFG_MAX_RATE:       r_max_rate   <= i_cfg_data[RCW-1:0];
                    arpg_pkg::CFG_ACCEL_STEP:     r_accel_step <= i_cfg_data[RCW-1:0];
                    arpg_pkg::CFG_HALF_INV_ACCEL: r_half_inv   <= i_cfg_data[RCW-1:0];
                    arpg_pkg::CFG_TICK_PERIOD:    r_period     <= i_cfg_data[PDW-1:0];
                    arpg_pkg::CFG_DONE_THRESHOLD: r_done_thr   <= i_cfg_data[RCW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == arpg_pkg::S_WAIT) && mul_stat.done) begin
            case (r_op)
                arpg_pkg::OP_SQ_ACC:   r_t      <= MA'(t_full);
                arpg_pkg::OP_DIST_ACC: r_d_acc  <= n_dist;
                arpg_pkg::OP_SQ_DEC:   r_t      <= n_t_cap;
                arpg_pkg::OP_DIST_DEC: r_d_dec  <= n_dist;
                arpg_pkg::OP_TRAVEL:   r_travel <= n_travel;
                default: ;
            endcase
        end
        if (r_state == arpg_pkg::S_DECIDE) begin
            r_new_rate <= n_new_rate;
        end
        if (out_load) begin
            r_o_rate <= IOW'({{IOW{r_rate[DW-1]}}, r_rate});
            r_o_rem  <= IOW'({{IOW{r_rem[DW-1]}}, r_rem});
            r_o_done <= n_done;
        end
    end

    assign o_in_stall      = (r_state != arpg_pkg::S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_rate_out      = r_o_rate;
    assign o_remaining_out = r_o_rem;
    assign o_done_res      = r_o_done;

    a_idle_mult_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == arpg_pkg::S_IDLE) |-> !mul_stat.busy)
        else $error("multiplier busy while sequencer idle");

    a_take_then_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an item was taken");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == arpg_pkg::S_FINISH))
        else $error("result presented outside the finish step");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_stat.done |-> (r_state == arpg_pkg::S_WAIT))
        else $error("product finished with no step waiting for it");

endmodule
